// ----- hdl/mme_pkg.sv -----
// shared constants, types and helpers for the matrix multiply engine
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_CAP     = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int CNT_W       = 3;
    localparam int DIM_W       = 4;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 36;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_ROWS_A = 2'd0;
    localparam logic [1:0] CFG_INNER  = 2'd1;
    localparam logic [1:0] CFG_COLS_B = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic              a_we;
        logic              b_we;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] a_rd_addr;
        logic [ADDR_W-1:0] b_rd_addr;
        logic              first;
        logic              lastm;
        logic              out_load;
        logic              out_err;
        logic [2:0]        out_row;
        logic [2:0]        out_col;
        logic              out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic mac_done;
        logic out_free;
    } dp_status_t;

    function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > DIM_CAP)
            r = DIM_W'(DIM_CAP);
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- hdl/mme_if.sv -----
// valid/ready channel interfaces for input words and result words
interface mme_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [5:0]         index;
    logic signed [15:0] value;

    modport source (output valid, output command, output index, output value, input ready);
    modport sink (input valid, input command, input index, input value, output ready);
endinterface

interface mme_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [35:0] sum;
    logic               last;
    logic               status;

    modport source (output valid, output row, output col, output sum, output last,
                    output status, input ready);
    modport sink (input valid, input row, input col, input sum, input last,
                  input status, output ready);
endinterface

// ----- hdl/matrix_multiply_engine_unit.sv -----
// top level of the matrix multiply engine
// load words give no result
// a compute word runs, per column: inner reads of the shared multiply-accumulate, a drain of its
// pipeline, and a push into the output register once that register is free
// a row out of range gives one error word once the output register is free
// reset clears control and sets rows_a, inner and cols_b to 8; element stores are not cleared
module matrix_multiply_engine_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    mme_in_if.sink     item,
    mme_out_if.source  result
);
    import mme_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .status    (status),
        .cmd       (cmd)
    );

    mme_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ld_value (item.value),
        .status   (status),
        .result   (result)
    );

    // never overwrite a word still waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n) cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    // reads are issued only after the previous column has drained
    assert property (@(posedge clk) disable iff (!rst_n) cmd.rd_en |-> !status.mac_done)
        else $error("mac completion during read issue");

    // no input word is taken while the stores are being read
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |-> !cmd.rd_en)
        else $error("input accepted during compute");

    // an error word is always the final word of its item and carries a zero sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status) |-> (result.last && result.sum == '0))
        else $error("malformed error word");

endmodule

// ----- hdl/mme_ram.sv -----
// generic simple dual-port ram with registered read
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mme_ctrl.sv -----
// controller: config registers, item acceptance and row/column sequencing
module mme_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data,
    mme_in_if.sink              item,
    input  mme_pkg::dp_status_t status,
    output mme_pkg::dp_cmd_t    cmd
);
    import mme_pkg::*;

    typedef enum logic [4:0] {
        IDLE  = 5'b00001,
        ISSUE = 5'b00010,
        DRAIN = 5'b00100,
        PUSH  = 5'b01000,
        ERR   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] rows_a_reg, rows_a_next;
    logic [DIM_W-1:0] inner_reg, inner_next;
    logic [DIM_W-1:0] cols_b_reg, cols_b_next;
    logic [2:0]       row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] m_reg, m_next;

    logic [DIM_W-1:0] nr, nk, nc;
    logic             accept;
    logic             in_store;
    logic             m_last;
    logic             col_last;

    assign nr       = eff_dim(rows_a_reg);
    assign nk       = eff_dim(inner_reg);
    assign nc       = eff_dim(cols_b_reg);
    assign accept   = item.valid && item.ready;
    assign in_store = int'(item.index) < STORE_DEPTH;
    assign m_last   = ({1'b0, m_reg} == nk - DIM_W'(1));
    assign col_last = ({1'b0, col_reg} == nc - DIM_W'(1));

    assign item.ready = (state_reg == IDLE);

    always_comb
    begin
        rows_a_next = rows_a_reg;
        inner_next  = inner_reg;
        cols_b_next = cols_b_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS_A: rows_a_next = cfg_data;
                CFG_INNER:  inner_next  = cfg_data;
                CFG_COLS_B: cols_b_next = cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        m_next     = m_reg;

        cmd           = '0;
        cmd.wr_addr   = ADDR_W'(item.index);
        cmd.a_rd_addr = ADDR_W'(int'(row_reg) * MAX_DIM + int'(m_reg));
        cmd.b_rd_addr = ADDR_W'(int'(m_reg) * MAX_DIM + int'(col_reg));
        cmd.first     = (m_reg == '0);
        cmd.lastm     = m_last;
        cmd.out_row   = row_reg;
        cmd.out_col   = 3'(col_reg);
        cmd.out_last  = col_last;

        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    priority if (item.command == CMD_LOAD_A)
                    begin
                        cmd.a_we = in_store;
                    end
                    else if (item.command == CMD_LOAD_B)
                    begin
                        cmd.b_we = in_store;
                    end
                    else if (item.command == CMD_COMPUTE)
                    begin
                        if ({2'b00, item.index} >= {4'b0000, nr})
                        begin
                            state_next = ERR;
                        end
                        else
                        begin
                            row_next   = 3'(item.index);
                            col_next   = '0;
                            m_next     = '0;
                            state_next = ISSUE;
                        end
                    end
                    else
                    begin
                        state_next = IDLE;
                    end
                end
            end
            ISSUE:
            begin
                cmd.rd_en = 1'b1;
                if (m_last)
                begin
                    m_next     = '0;
                    state_next = DRAIN;
                end
                else
                begin
                    m_next = m_reg + CNT_W'(1);
                end
            end
            DRAIN:
            begin
                if (status.mac_done)
                begin
                    state_next = PUSH;
                end
            end
            PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (col_last)
                    begin
                        state_next = IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + CNT_W'(1);
                        state_next = ISSUE;
                    end
                end
            end
            ERR:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_err  = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            rows_a_reg <= DIM_RESET;
            inner_reg  <= DIM_RESET;
            cols_b_reg <= DIM_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
            m_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rows_a_reg <= rows_a_next;
            inner_reg  <= inner_next;
            cols_b_reg <= cols_b_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            m_reg      <= m_next;
        end
    end

endmodule

// ----- hdl/mme_datapath.sv -----
// datapath: element stores, pipelined multiply-accumulate and output register
module mme_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mme_pkg::dp_cmd_t          cmd,
    input  logic signed [15:0]        ld_value,
    output mme_pkg::dp_status_t       status,
    mme_out_if.source                 result
);
    import mme_pkg::*;

    logic [ELEM_W-1:0]        a_rdata, b_rdata;

    logic                     v1_reg, first1_reg, last1_reg;
    logic                     v2_reg, first2_reg, last2_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;

    logic                     out_valid_reg, out_valid_next;
    logic [2:0]               out_row_reg;
    logic [2:0]               out_col_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_last_reg;
    logic                     out_status_reg;

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_a_store (
        .clk   (clk),
        .we    (cmd.a_we),
        .waddr (cmd.wr_addr),
        .wdata (ld_value),
        .re    (cmd.rd_en),
        .raddr (cmd.a_rd_addr),
        .rdata (a_rdata)
    );

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_b_store (
        .clk   (clk),
        .we    (cmd.b_we),
        .waddr (cmd.wr_addr),
        .wdata (ld_value),
        .re    (cmd.rd_en),
        .raddr (cmd.b_rd_addr),
        .rdata (b_rdata)
    );

    always_comb
    begin
        acc_next = acc_reg;
        if (v2_reg)
        begin
            if (first2_reg)
                acc_next = SUM_W'(prod_reg);
            else
                acc_next = acc_reg + SUM_W'(prod_reg);
        end
    end

    // multiply stage, registered before the accumulate, and the accumulator register
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= $signed(a_rdata) * $signed(b_rdata);
        end
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            last1_reg  <= 1'b0;
            v2_reg     <= 1'b0;
            first2_reg <= 1'b0;
            last2_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            v1_reg     <= cmd.rd_en;
            first1_reg <= cmd.first;
            last1_reg  <= cmd.lastm;
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
            done_reg   <= v2_reg && last2_reg;
        end
    end

    assign status.mac_done = done_reg;
    assign status.out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_err)
            begin
                out_row_reg    <= '0;
                out_col_reg    <= '0;
                out_sum_reg    <= '0;
                out_last_reg   <= 1'b1;
                out_status_reg <= 1'b1;
            end
            else
            begin
                out_row_reg    <= cmd.out_row;
                out_col_reg    <= cmd.out_col;
                out_sum_reg    <= acc_reg;
                out_last_reg   <= cmd.out_last;
                out_status_reg <= 1'b0;
            end
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.row    = out_row_reg;
    assign result.col    = out_col_reg;
    assign result.sum    = out_sum_reg;
    assign result.last   = out_last_reg;
    assign result.status = out_status_reg;

endmodule
